// File: design/tbw_pkg.sv
// types, widths and helper functions for the triangle barycentric weights core
// no dependencies
`default_nettype none
package tbw_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int COORD_FRAC_BITS  = 4;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int WEIGHT_INT_BITS  = 4;
    localparam int WEIGHT_WIDTH     = WEIGHT_FRAC_BITS + WEIGHT_INT_BITS;

    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int NA_W    = CROSS_W + 2;
    localparam int SAT_SH  = WEIGHT_INT_BITS - 1;
    localparam int DEN_W   = CROSS_W + SAT_SH;
    localparam int REM_W   = DEN_W + 1;
    localparam int QBITS   = WEIGHT_WIDTH - 1;
    localparam int LANES   = 3;

    localparam logic [CROSS_W-1:0] MIN_DET = CROSS_W'(1) << (2 * COORD_FRAC_BITS);
    localparam logic [WEIGHT_WIDTH-1:0] W_NEG_ONE =
        WEIGHT_WIDTH'(0) - (WEIGHT_WIDTH'(1) << WEIGHT_FRAC_BITS);
    localparam logic [WEIGHT_WIDTH-1:0] W_MAX = {1'b0, {QBITS{1'b1}}};
    localparam logic [WEIGHT_WIDTH-1:0] W_MIN = {1'b1, {QBITS{1'b0}}};

    // front end, multiply, cross, numerators, divider setup, divider steps, output
    localparam int LATENCY = 5 + QBITS + 1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]      t_diff;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [CROSS_W-1:0]     t_cross;
    typedef logic signed [NA_W-1:0]        t_na;

    typedef struct packed {
        t_coord vertex_a_x;
        t_coord vertex_a_y;
        t_coord vertex_b_x;
        t_coord vertex_b_y;
        t_coord vertex_c_x;
        t_coord vertex_c_y;
        t_coord sample_x;
        t_coord sample_y;
    } t_item;

    typedef struct packed {
        logic                            rejected;
        logic signed [WEIGHT_WIDTH-1:0]  weight_a;
        logic signed [WEIGHT_WIDTH-1:0]  weight_b;
        logic signed [WEIGHT_WIDTH-1:0]  weight_c;
    } t_result;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QBITS-1:0] quo;
        logic             neg;
        logic             sat;
    } t_div_lane;

    typedef struct packed {
        logic                        rej;
        logic [DEN_W-1:0]            den;
        t_div_lane [LANES-1:0]       lane;
    } t_div_stage;

    function automatic logic [CROSS_W-1:0] mag_cross(input t_cross v);
        logic [CROSS_W-1:0] u;
        u = v;
        return v[CROSS_W-1] ? (CROSS_W'(0) - u) : u;
    endfunction

    function automatic logic [NA_W-1:0] mag_na(input t_na v);
        logic [NA_W-1:0] u;
        u = v;
        return v[NA_W-1] ? (NA_W'(0) - u) : u;
    endfunction

    // one restoring division step against the scaled divisor
    function automatic t_div_lane div_step(input t_div_lane l, input logic [DEN_W-1:0] den);
        t_div_lane        o;
        logic [REM_W-1:0] r2;
        o  = l;
        r2 = {l.rem[REM_W-2:0], 1'b0};
        if (r2 >= {1'b0, den}) begin
            o.rem = r2 - {1'b0, den};
            o.quo = {l.quo[QBITS-2:0], 1'b1};
        end else begin
            o.rem = r2;
            o.quo = {l.quo[QBITS-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic [WEIGHT_WIDTH-1:0] lane_weight(input t_div_lane l);
        logic [WEIGHT_WIDTH-1:0] q;
        q = {1'b0, l.quo};
        if (l.sat) begin
            return l.neg ? W_MIN : W_MAX;
        end
        return l.neg ? (WEIGHT_WIDTH'(0) - q) : q;
    endfunction

endpackage
`default_nettype wire

// File: design/triangle_barycentric_weights_core.sv
// Barycentric weights of a sample point in a 2D triangle: takes one item every clock
// cycle and returns its result on o_result with o_result_valid once it has passed the edge-vector,
// product, cross-product, numerator, divider and output registers; busy stays low, since
// nothing downstream can stall. The divider resolves one quotient bit per pipeline stage
// for the three weights in parallel. Depends on tbw_pkg.
`default_nettype none
module triangle_barycentric_weights_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire tbw_pkg::t_item i_item,
    output logic                o_result_valid,
    output tbw_pkg::t_result    o_result
);
    import tbw_pkg::*;

    // stage 1: edge vectors
    logic  r_v1;
    t_diff r_abx, r_aby, r_acx, r_acy, r_apx, r_apy;
    // stage 2: products
    logic  r_v2;
    t_prod r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    // stage 3: cross products
    logic   r_v3;
    t_cross r_det, r_nb, r_nc;
    // stage 4: numerator of a, flags, magnitudes
    logic               r_v4, r_rej4;
    logic [CROSS_W-1:0] r_mdet;
    logic [NA_W-1:0]    r_ma;
    logic [CROSS_W-1:0] r_mb, r_mc;
    logic [LANES-1:0]   r_neg4;
    // divider pipeline
    logic       r_dv_vld [0:QBITS];
    t_div_stage r_dv     [0:QBITS];
    // output
    logic    r_out_vld;
    t_result r_out;

    t_na                 n_na;
    logic [DEN_W-1:0]    n_den;
    t_div_stage          n_dv0;
    logic [LANES-1:0][NA_W-1:0] n_num;

    assign busy = 1'b0;

    always_comb begin
        n_na = t_na'(r_det) - t_na'(r_nb) - t_na'(r_nc);
    end

    always_comb begin
        n_den    = {r_mdet, SAT_SH'(0)};
        n_num[0] = r_ma;
        n_num[1] = NA_W'(r_mb);
        n_num[2] = NA_W'(r_mc);
        n_dv0.rej = r_rej4;
        n_dv0.den = n_den;
        for (int k = 0; k < LANES; k++) begin
            n_dv0.lane[k].rem = REM_W'(n_num[k]);
            n_dv0.lane[k].quo = '0;
            n_dv0.lane[k].neg = r_neg4[k];
            n_dv0.lane[k].sat = DEN_W'(n_num[k]) >= n_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_out_vld <= 1'b0;
            for (int s = 0; s <= QBITS; s++) begin
                r_dv_vld[s] <= 1'b0;
            end
        end else begin
            r_v1        <= start && !busy;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_dv_vld[0] <= r_v4;
            for (int s = 0; s < QBITS; s++) begin
                r_dv_vld[s+1] <= r_dv_vld[s];
            end
            r_out_vld <= r_dv_vld[QBITS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_abx <= t_diff'(i_item.vertex_b_x) - t_diff'(i_item.vertex_a_x);
        r_aby <= t_diff'(i_item.vertex_b_y) - t_diff'(i_item.vertex_a_y);
        r_acx <= t_diff'(i_item.vertex_c_x) - t_diff'(i_item.vertex_a_x);
        r_acy <= t_diff'(i_item.vertex_c_y) - t_diff'(i_item.vertex_a_y);
        r_apx <= t_diff'(i_item.sample_x)   - t_diff'(i_item.vertex_a_x);
        r_apy <= t_diff'(i_item.sample_y)   - t_diff'(i_item.vertex_a_y);

        r_p0 <= t_prod'(r_abx) * t_prod'(r_acy);
        r_p1 <= t_prod'(r_acx) * t_prod'(r_aby);
        r_p2 <= t_prod'(r_apx) * t_prod'(r_acy);
        r_p3 <= t_prod'(r_acx) * t_prod'(r_apy);
        r_p4 <= t_prod'(r_abx) * t_prod'(r_apy);
        r_p5 <= t_prod'(r_apx) * t_prod'(r_aby);

        r_det <= t_cross'(r_p0) - t_cross'(r_p1);
        r_nb  <= t_cross'(r_p2) - t_cross'(r_p3);
        r_nc  <= t_cross'(r_p4) - t_cross'(r_p5);

        r_mdet <= mag_cross(r_det);
        r_ma   <= mag_na(n_na);
        r_mb   <= mag_cross(r_nb);
        r_mc   <= mag_cross(r_nc);
        r_neg4 <= {r_nc[CROSS_W-1] != r_det[CROSS_W-1],
                   r_nb[CROSS_W-1] != r_det[CROSS_W-1],
                   n_na[NA_W-1]    != r_det[CROSS_W-1]};
        // degenerate triangle, or weight of a below zero
        r_rej4 <= (mag_cross(r_det) < MIN_DET)
                  || ((n_na != '0) && (n_na[NA_W-1] != r_det[CROSS_W-1]));

        r_dv[0] <= n_dv0;
        for (int s = 0; s < QBITS; s++) begin
            r_dv[s+1].rej <= r_dv[s].rej;
            r_dv[s+1].den <= r_dv[s].den;
            for (int k = 0; k < LANES; k++) begin
                r_dv[s+1].lane[k] <= div_step(r_dv[s].lane[k], r_dv[s].den);
            end
        end

        if (r_dv[QBITS].rej) begin
            r_out.rejected <= 1'b1;
            r_out.weight_a <= W_NEG_ONE;
            r_out.weight_b <= '0;
            r_out.weight_c <= '0;
        end else begin
            r_out.rejected <= 1'b0;
            r_out.weight_a <= lane_weight(r_dv[QBITS].lane[0]);
            r_out.weight_b <= lane_weight(r_dv[QBITS].lane[1]);
            r_out.weight_c <= lane_weight(r_dv[QBITS].lane[2]);
        end
    end

    assign o_result_valid = r_out_vld;
    assign o_result       = r_out;

    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_result_valid)
        else $error("item taken without result after fixed latency");

    a_reject_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.rejected) |->
            (o_result.weight_a == W_NEG_ONE && o_result.weight_b == '0
             && o_result.weight_c == '0))
        else $error("rejected item with wrong weights");

    a_weight_a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.rejected) |-> !o_result.weight_a[WEIGHT_WIDTH-1])
        else $error("accepted item with negative weight of a");

endmodule
`default_nettype wire

// File: test/tb_top.sv
// testbench for triangle_barycentric_weights_core: directed table then random items,
// each result checked against a predictor of the barycentric weights. depends on tbw_pkg
module tb_top;
    import tbw_pkg::*;

    localparam int N_RANDOM = 1830;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    o_result_valid;
    t_result o_result;

    t_result weights_due[$];
    int      n_fail;
    bit      done_sending;

    triangle_barycentric_weights_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_result_valid(o_result_valid), .o_result(o_result)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // quotient in Q4.16, truncated toward zero, saturated
    function automatic logic [WEIGHT_WIDTH-1:0] weight_quot(input longint num, input longint den);
        bit      neg;
        longint  a, d, ip, r, q;
        neg = (num < 0) != (den < 0);
        a = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        ip = a / d;
        r = a % d;
        if (ip >= (64'sd1 << (WEIGHT_INT_BITS - 1)))
            return neg ? W_MIN : W_MAX;
        q = ip;
        for (int i = 0; i < WEIGHT_FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 1;
            end
        end
        return neg ? WEIGHT_WIDTH'(-q) : WEIGHT_WIDTH'(q);
    endfunction

    function automatic t_result barycentric(input t_item it);
        t_result res;
        longint  abx, aby, acx, acy, apx, apy, det, nb, nc, na, mdet;
        abx = longint'(it.vertex_b_x) - it.vertex_a_x;
        aby = longint'(it.vertex_b_y) - it.vertex_a_y;
        acx = longint'(it.vertex_c_x) - it.vertex_a_x;
        acy = longint'(it.vertex_c_y) - it.vertex_a_y;
        apx = longint'(it.sample_x) - it.vertex_a_x;
        apy = longint'(it.sample_y) - it.vertex_a_y;
        det = abx * acy - acx * aby;
        res.rejected = 1'b1;
        res.weight_a = W_NEG_ONE;
        res.weight_b = '0;
        res.weight_c = '0;
        mdet = det < 0 ? -det : det;
        if (mdet < (64'sd1 << (2 * COORD_FRAC_BITS)))
            return res;
        nb = apx * acy - acx * apy;
        nc = abx * apy - apx * aby;
        na = det - nb - nc;
        if (na != 0 && ((na < 0) != (det < 0)))
            return res;
        res.rejected = 1'b0;
        res.weight_a = weight_quot(na, det);
        res.weight_b = weight_quot(nb, det);
        res.weight_c = weight_quot(nc, det);
        return res;
    endfunction

    function automatic t_item mk_item(input int ax, ay, bx, by, cx, cy, px, py);
        t_item it;
        it.vertex_a_x = t_coord'(ax); it.vertex_a_y = t_coord'(ay);
        it.vertex_b_x = t_coord'(bx); it.vertex_b_y = t_coord'(by);
        it.vertex_c_x = t_coord'(cx); it.vertex_c_y = t_coord'(cy);
        it.sample_x = t_coord'(px);   it.sample_y = t_coord'(py);
        return it;
    endfunction

    function automatic t_coord rnd_coord();
        case ($urandom_range(0, 5))
            0:       return t_coord'($urandom);
            1:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return t_coord'($signed($urandom_range(0, 4095)) - 2048);
        endcase
    endfunction

    // mostly a proper triangle with the sample near it, some fully random noise
    function automatic t_item rnd_item();
        t_item it;
        int    base_x, base_y, span;
        it = t_item'({$urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(0, 9) < 2)
            return it;
        if ($urandom_range(0, 9) == 0) begin
            it.vertex_a_x = rnd_coord(); it.vertex_a_y = rnd_coord();
            it.vertex_b_x = rnd_coord(); it.vertex_b_y = rnd_coord();
            it.vertex_c_x = rnd_coord(); it.vertex_c_y = rnd_coord();
            it.sample_x = rnd_coord();   it.sample_y = rnd_coord();
            return it;
        end
        span = 1 << $urandom_range(2, 14);
        base_x = $signed($urandom_range(0, 32767)) - 16384;
        base_y = $signed($urandom_range(0, 32767)) - 16384;
        it.vertex_a_x = t_coord'(base_x + $signed($urandom_range(0, span)));
        it.vertex_a_y = t_coord'(base_y + $signed($urandom_range(0, span)));
        it.vertex_b_x = t_coord'(base_x + $signed($urandom_range(0, span)));
        it.vertex_b_y = t_coord'(base_y + $signed($urandom_range(0, span)));
        it.vertex_c_x = t_coord'(base_x + $signed($urandom_range(0, span)));
        it.vertex_c_y = t_coord'(base_y + $signed($urandom_range(0, span)));
        it.sample_x = t_coord'(base_x + $signed($urandom_range(0, span)));
        it.sample_y = t_coord'(base_y + $signed($urandom_range(0, span)));
        return it;
    endfunction

    // hands one item over, with random idle bursts when gaps are enabled
    task automatic send_item(input t_item it, input bit gaps);
        if (gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        weights_due.push_back(barycentric(it));
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_result_valid) begin
            if (weights_due.size() == 0) begin
                $error("result with no item pending: %p", o_result);
                n_fail++;
            end else begin
                exp_r = weights_due.pop_front();
                if (o_result.rejected !== exp_r.rejected) begin
                    $error("rejected: expected %0b, got %0b", exp_r.rejected, o_result.rejected);
                    n_fail++;
                end
                if (o_result.weight_a !== exp_r.weight_a) begin
                    $error("weight_a: expected %0d, got %0d", exp_r.weight_a, o_result.weight_a);
                    n_fail++;
                end
                if (o_result.weight_b !== exp_r.weight_b) begin
                    $error("weight_b: expected %0d, got %0d", exp_r.weight_b, o_result.weight_b);
                    n_fail++;
                end
                if (o_result.weight_c !== exp_r.weight_c) begin
                    $error("weight_c: expected %0d, got %0d", exp_r.weight_c, o_result.weight_c);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("[triangle_barycentric_weights_core] ERROR");
        $finish;
    end

    initial begin
        t_item   dir_item [$];
        t_result dir_known [$];
        bit      dir_typed [$];
        t_result rej_r, unit_r;
        int      wait_n;

        rej_r  = '{rejected: 1'b1, weight_a: W_NEG_ONE, weight_b: '0, weight_c: '0};
        unit_r = '{rejected: 1'b0, weight_a: 20'sd65536, weight_b: '0, weight_c: '0};

        // all zero: degenerate
        dir_item.push_back(mk_item(0, 0, 0, 0, 0, 0, 0, 0));
        dir_known.push_back(rej_r); dir_typed.push_back(1);
        // collinear vertices
        dir_item.push_back(mk_item(0, 0, 16, 16, 32, 32, 5, 5));
        dir_known.push_back(rej_r); dir_typed.push_back(1);
        // determinant just under one square pixel
        dir_item.push_back(mk_item(0, 0, 15, 0, 0, 17, 0, 0));
        dir_known.push_back(rej_r); dir_typed.push_back(1);
        // determinant exactly one square pixel, sample on vertex a
        dir_item.push_back(mk_item(0, 0, 16, 0, 0, 16, 0, 0));
        dir_known.push_back(unit_r); dir_typed.push_back(1);
        // sample on vertex a, negative orientation
        dir_item.push_back(mk_item(0, 0, 0, 160, 160, 0, 0, 0));
        dir_known.push_back(unit_r); dir_typed.push_back(1);
        // sample outside past edge bc: weight of a negative
        dir_item.push_back(mk_item(0, 0, 160, 0, 0, 160, 320, 320));
        dir_known.push_back(rej_r); dir_typed.push_back(1);
        // negative b and c weights allowed, saturation, extremes
        dir_item.push_back(mk_item(0, 0, 160, 0, 0, 160, -80, 40));
        dir_item.push_back(mk_item(0, 0, 16, 0, 0, 16, -32768, 32767));
        dir_item.push_back(mk_item(0, 0, 16, 0, 0, 16, 32767, -32768));
        dir_item.push_back(mk_item(-32768, -32768, 32767, -32768, -32768, 32767,
                                   -32768, -32768));
        dir_item.push_back(mk_item(32767, 32767, -32768, 32767, 32767, -32768, 0, 0));
        dir_item.push_back(mk_item(-32768, 32767, 32767, 32767, -32768, -32768,
                                   32767, -32768));
        dir_item.push_back(mk_item(32767, -32768, -32768, -32768, 32767, 32767,
                                   -32768, 32767));
        dir_item.push_back(mk_item(0, 0, 160, 0, 0, 160, 53, 53));
        dir_item.push_back(mk_item(0, 0, 160, 0, 0, 160, 1, 1));
        dir_item.push_back(mk_item(-1, -1, -1, 32767, 32767, -1, 100, 100));
        for (int k = 0; k < 10; k++) begin
            dir_known.push_back(rej_r);
            dir_typed.push_back(0);
        end

        n_fail = 0;
        done_sending = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_item[k]) begin
            if (dir_typed[k] && barycentric(dir_item[k]) !== dir_known[k]) begin
                $error("table row %0d disagrees with predictor", k);
                n_fail++;
            end
            send_item(dir_item[k], 1);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                // hold off until the pipeline has drained
                start <= 1'b0;
                @(posedge i_clk);
                while (weights_due.size() != 0) @(posedge i_clk);
            end
            send_item(rnd_item(), n < N_RANDOM - 300);
        end
        start <= 1'b0;

        wait_n = 0;
        while (weights_due.size() != 0 && wait_n < 10 * LATENCY + 100) begin
            @(posedge i_clk);
            wait_n++;
        end
        repeat (LATENCY + 5) @(posedge i_clk);
        if (n_fail == 0 && weights_due.size() == 0)
            $display("[triangle_barycentric_weights_core] OK");
        else
            $display("[triangle_barycentric_weights_core] ERROR");
        $finish;
    end
endmodule
